// ----- rtl/bounded_stack_drop_oldest_assert.svh -----
// Assertion macros used by the checker file.
// Every macro samples on clk and is switched off while rst is high.
`ifndef BOUNDED_STACK_DROP_OLDEST_ASSERT_SVH
`define BOUNDED_STACK_DROP_OLDEST_ASSERT_SVH

// Same-cycle implication.
`define BSDO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsdo: same-cycle check failed");

// Next-cycle implication.
`define BSDO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsdo: next-cycle check failed");

`endif

// ----- rtl/bsdo_pkg.sv -----
package bsdo_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int MSG_BYTES_DEF = 8;

  localparam int PAYLOAD_W = 64;
  localparam int LEN_W     = 4;
  localparam int FILL_W    = 5;
  localparam int LIMIT_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_EMPTY    = 3'd1;
  localparam logic [2:0] STS_DISABLED = 3'd2;
  localparam logic [2:0] STS_FULL     = 3'd3;
  localparam logic [2:0] STS_TOO_LONG = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     msg_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic                 dropped;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [LEN_W-1:0]     out_bytes;
    logic [FILL_W-1:0]    fill;
  } result_t;

endpackage

// ----- rtl/bounded_stack_drop_oldest.sv -----
// Bounded LIFO message store with drop-oldest overwrite.
// Requests arrive on item (push, pop newest, peek newest) and are taken at a
// rising edge where start is high and busy is low; busy then stays high until
// the item is finished. Exactly one result per item appears on result for one
// cycle, marked by done; the receiver cannot stall, so results never wait.
// After the accepting edge an item passes through ST_EXEC, where push,
// empty pop/peek and unused commands finish; pop/peek of a held entry also
// pass through ST_READ for the synchronous memory read. A new item may be
// started in the cycle that shows done, but no new item is taken while an
// earlier one is still in progress (busy holds it off).
// Configuration (limit, max_len) is written on cfg_valid/cfg_ready/cfg_index/
// cfg_data, always ready; write it only while the block is idle.
// Reset (rst, synchronous) empties the store, sets limit to no limit and
// max_len to the full message size. Entry memory contents are not cleared:
// only slots that a push wrote are ever read back.
module bounded_stack_drop_oldest
  import bsdo_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int DATA_W  = 8 * MSG_BYTES;
  localparam int ENTRY_W = DATA_W + LEN_W;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t state, state_next;

  // Latched request
  logic [1:0]        cmd_q;
  logic [DATA_W-1:0] data_q;
  logic [LEN_W-1:0]  bytes_q;

  // Configuration
  logic [LIMIT_W-1:0] limit_q;
  logic [LEN_W-1:0]   max_len_q;

  // Stack pointers
  logic [IDX_W-1:0] top, top_next;
  logic [CNT_W-1:0] count, count_next;

  // Entry memory: {length, payload}
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_we;
  logic [ENTRY_W-1:0] wr_entry;

  logic    done_next;
  result_t result_next;

  // Push decision terms
  logic             unlimited, disabled, too_long, full_hit, drop;
  logic [CMP_W-1:0] lim_ext, eff_lim;
  logic [DATA_W-1:0] byte_mask;
  logic [IDX_W-1:0]  newest, top_inc;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_q   <= '1;
      max_len_q <= LEN_W'(MSG_BYTES);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LIMIT:   limit_q   <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_LEN: max_len_q <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot arithmetic around the ring
  assign newest  = (top == '0) ? IDX_W'(DEPTH - 1) : top - 1'b1;
  assign top_inc = (top == IDX_W'(DEPTH - 1)) ? '0 : top + 1'b1;

  // Keep only the bytes below the message length
  always_comb begin
    for (int b = 0; b < MSG_BYTES; b++) begin
      byte_mask[8*b +: 8] = (LEN_W'(b) < bytes_q) ? 8'hFF : 8'h00;
    end
  end

  assign unlimited = limit_q[LIMIT_W-1];
  assign disabled  = !unlimited && (limit_q[LIMIT_W-2:0] == '0);
  assign too_long  = (bytes_q > max_len_q) || (bytes_q > LEN_W'(MSG_BYTES));
  assign full_hit  = unlimited && (count >= CNT_W'(DEPTH));
  assign lim_ext   = CMP_W'(limit_q[LIMIT_W-2:0]);
  // A limit above the depth acts as the depth
  assign eff_lim   = (lim_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : lim_ext;
  assign drop      = !unlimited && (CMP_W'(count) >= eff_lim) && (count != '0);
  assign wr_entry  = {bytes_q, data_q & byte_mask};

  always_comb begin
    state_next  = state;
    top_next    = top;
    count_next  = count;
    mem_we      = 1'b0;
    done_next   = 1'b0;
    result_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next       = ST_IDLE;
        done_next        = 1'b1;
        result_next.fill = FILL_W'(count);
        unique case (cmd_q) inside
          CMD_PUSH: begin
            if (disabled) begin
              result_next.status = STS_DISABLED;
            end else if (too_long) begin
              result_next.status = STS_TOO_LONG;
            end else if (full_hit) begin
              result_next.status = STS_FULL;
            end else begin
              // Dropping the oldest just releases its slot: count holds
              mem_we              = 1'b1;
              top_next            = top_inc;
              count_next          = drop ? count : count + 1'b1;
              result_next.dropped = drop;
              result_next.fill    = FILL_W'(count_next);
            end
          end
          CMD_POP, CMD_PEEK: begin
            if (count == '0) begin
              result_next.status = STS_EMPTY;
            end else begin
              // Memory read of the newest slot lands next cycle
              state_next = ST_READ;
              done_next  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_READ: begin
        state_next              = ST_IDLE;
        done_next               = 1'b1;
        result_next.out_payload = PAYLOAD_W'(rd_q[DATA_W-1:0]);
        result_next.out_bytes   = rd_q[ENTRY_W-1 -: LEN_W];
        if (cmd_q == CMD_POP) begin
          top_next   = newest;
          count_next = count - 1'b1;
        end
        result_next.fill = FILL_W'(count_next);
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      top   <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      top   <= top_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q   <= item.cmd;
      data_q  <= item.payload[DATA_W-1:0];
      bytes_q <= item.msg_bytes;
    end
    result <= result_next;
  end

  // Entry memory: one write port at top, registered read of the newest slot
  always_ff @(posedge clk) begin
    if (mem_we) mem[top] <= wr_entry;
    rd_q <= mem[newest];
  end

endmodule

// ----- rtl/bsdo_checker.sv -----
`include "bounded_stack_drop_oldest_assert.svh"

module bsdo_checker
  import bsdo_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // An accepted item holds off the next one
  `BSDO_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // The result cycle frees the block
  `BSDO_ASSERT_NOW(a_done_idle, done, !busy)
  // One result per item, never two in a row
  `BSDO_ASSERT_NEXT(a_done_single, done, !done)
  // Empty answers carry no message and no entries
  `BSDO_ASSERT_NOW(a_empty_clean, done && (result.status == STS_EMPTY),
                   (result.fill == '0) && (result.out_bytes == '0))
  // Only a stored push may drop
  `BSDO_ASSERT_NOW(a_drop_ok, done && result.dropped, result.status == STS_OK)

endmodule

bind bounded_stack_drop_oldest bsdo_checker u_bsdo_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
